FILE: design/sqenc_pkg.sv
// sqenc_pkg: S-box, GF(2^8) helpers and round functions for the Square encrypt core.
// Used by square_cipher_encrypt_core. No dependencies.
package sqenc_pkg;

	localparam int BLK_W = 128;
	localparam logic [8:0] FIELD_POLY = 9'h1f5;

	localparam logic REG_KEY_LOW  = 1'b0;
	localparam logic REG_KEY_HIGH = 1'b1;

	localparam logic [7:0] SBOX [0:255] = '{
		8'hb1,8'hce,8'hc3,8'h95,8'h5a,8'had,8'he7,8'h02,8'h4d,8'h44,8'hfb,8'h91,8'h0c,8'h87,8'ha1,8'h50,
		8'hcb,8'h67,8'h54,8'hdd,8'h46,8'h8f,8'he1,8'h4e,8'hf0,8'hfd,8'hfc,8'heb,8'hf9,8'hc4,8'h1a,8'h6e,
		8'h5e,8'hf5,8'hcc,8'h8d,8'h1c,8'h56,8'h43,8'hfe,8'h07,8'h61,8'hf8,8'h75,8'h59,8'hff,8'h03,8'h22,
		8'h8a,8'hd1,8'h13,8'hee,8'h88,8'h00,8'h0e,8'h34,8'h15,8'h80,8'h94,8'he3,8'hed,8'hb5,8'h53,8'h23,
		8'h4b,8'h47,8'h17,8'ha7,8'h90,8'h35,8'hab,8'hd8,8'hb8,8'hdf,8'h4f,8'h57,8'h9a,8'h92,8'hdb,8'h1b,
		8'h3c,8'hc8,8'h99,8'h04,8'h8e,8'he0,8'hd7,8'h7d,8'h85,8'hbb,8'h40,8'h2c,8'h3a,8'h45,8'hf1,8'h42,
		8'h65,8'h20,8'h41,8'h18,8'h72,8'h25,8'h93,8'h70,8'h36,8'h05,8'hf2,8'h0b,8'ha3,8'h79,8'hec,8'h08,
		8'h27,8'h31,8'h32,8'hb6,8'h7c,8'hb0,8'h0a,8'h73,8'h5b,8'h7b,8'hb7,8'h81,8'hd2,8'h0d,8'h6a,8'h26,
		8'h9e,8'h58,8'h9c,8'h83,8'h74,8'hb3,8'hac,8'h30,8'h7a,8'h69,8'h77,8'h0f,8'hae,8'h21,8'hde,8'hd0,
		8'h2e,8'h97,8'h10,8'ha4,8'h98,8'ha8,8'hd4,8'h68,8'h2d,8'h62,8'h29,8'h6d,8'h16,8'h49,8'h76,8'hc7,
		8'he8,8'hc1,8'h96,8'h37,8'he5,8'hca,8'hf4,8'he9,8'h63,8'h12,8'hc2,8'ha6,8'h14,8'hbc,8'hd3,8'h28,
		8'haf,8'h2f,8'he6,8'h24,8'h52,8'hc6,8'ha0,8'h09,8'hbd,8'h8c,8'hcf,8'h5d,8'h11,8'h5f,8'h01,8'hc5,
		8'h9f,8'h3d,8'ha2,8'h9b,8'hc9,8'h3b,8'hbe,8'h51,8'h19,8'h1f,8'h3f,8'h5c,8'hb2,8'hef,8'h4a,8'hcd,
		8'hbf,8'hba,8'h6f,8'h64,8'hd9,8'hf3,8'h3e,8'hb4,8'haa,8'hdc,8'hd5,8'h06,8'hc0,8'h7e,8'hf6,8'h66,
		8'h6c,8'h84,8'h71,8'h38,8'hb9,8'h1d,8'h7f,8'h9d,8'h48,8'h8b,8'h2a,8'hda,8'ha5,8'h33,8'h82,8'h39,
		8'hd6,8'h78,8'h86,8'hfa,8'he4,8'h2b,8'ha9,8'h1e,8'h89,8'h60,8'h6b,8'hea,8'h55,8'h4c,8'hf7,8'he2
	};

	function automatic logic [7:0] gf_double(input logic [7:0] v);
		logic [8:0] t;
		t = {v, 1'b0};
		if (t[8]) begin
			t = t ^ FIELD_POLY;
		end
		return t[7:0];
	endfunction

	// round constant for schedule step r (1 for the first step, doubled after)
	function automatic logic [7:0] round_const(input int unsigned r);
		logic [7:0] v;
		v = 8'h01;
		for (int unsigned i = 1; i < 8; i++) begin
			if (i < r) begin
				v = gf_double(v);
			end
		end
		return v;
	endfunction

	// theta: each row times circulant (2,3,1,1)
	function automatic logic [BLK_W-1:0] mix_rows(input logic [BLK_W-1:0] m);
		logic [BLK_W-1:0] t;
		logic [7:0] a0, a1, a2, a3;
		t = '0;
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				a0 = m[8*(4*r + c) +: 8];
				a1 = m[8*(4*r + ((c + 1) % 4)) +: 8];
				a2 = m[8*(4*r + ((c + 2) % 4)) +: 8];
				a3 = m[8*(4*r + ((c + 3) % 4)) +: 8];
				t[8*(4*r + c) +: 8] = gf_double(a0) ^ a1 ^ gf_double(a1) ^ a2 ^ a3;
			end
		end
		return t;
	endfunction

	// gamma then pi: byte (r,c) of the result is S(byte (c,r))
	function automatic logic [BLK_W-1:0] sub_transpose(input logic [BLK_W-1:0] m);
		logic [BLK_W-1:0] t;
		t = '0;
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				t[8*(4*r + c) +: 8] = SBOX[m[8*(4*c + r) +: 8]];
			end
		end
		return t;
	endfunction

	function automatic logic [BLK_W-1:0] next_key(input logic [BLK_W-1:0] kin,
			input logic [7:0] rc);
		logic [7:0] k [0:15];
		logic [7:0] old12;
		logic [BLK_W-1:0] t;
		t = '0;
		for (int i = 0; i < 16; i++) begin
			k[i] = kin[8*i +: 8];
		end
		old12 = k[12];
		k[0] = k[0] ^ rc ^ k[13];
		k[4] = k[4] ^ k[0]; k[8] = k[8] ^ k[4]; k[12] = k[12] ^ k[8];
		k[1] = k[1] ^ k[14];
		k[5] = k[5] ^ k[1]; k[9] = k[9] ^ k[5]; k[13] = k[13] ^ k[9];
		k[2] = k[2] ^ k[15];
		k[6] = k[6] ^ k[2]; k[10] = k[10] ^ k[6]; k[14] = k[14] ^ k[10];
		k[3] = k[3] ^ old12;
		k[7] = k[7] ^ k[3]; k[11] = k[11] ^ k[7]; k[15] = k[15] ^ k[11];
		for (int i = 0; i < 16; i++) begin
			t[8*i +: 8] = k[i];
		end
		return t;
	endfunction

endpackage

FILE: design/square_cipher_encrypt_core.sv
// square_cipher_encrypt_core: reduced Square block encryption, one round per pipeline stage.
// Depends on sqenc_pkg (S-box, theta, key schedule step).
//
//  channel | signals                                   | dir | notes
//  --------+-------------------------------------------+-----+---------------------------
//  in      | in_valid, in_ready, plain_low, plain_high | in  | one 128-bit block per word
//  out     | out_valid, out_ready, cipher_low/high     | out | one ciphertext word per block
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | in  | 0: key_low, 1: key_high
//
// ROUNDS+1 stages: whitening into the input stage, then one round per stage; a block taken
// into blk_s[0] moves on through blk_s[1] to blk_s[ROUNDS], the stage that drives out.
// Throughput one block per cycle unless out stalls; stages advance independently, so bubbles
// collapse while the output stalls and blocks are still taken until every stage is full.
// Round keys are a registered chain off the key registers, rkey_q[1] to rkey_q[ROUNDS],
// settling in that order after a key write or reset; cfg_ready is always high.
module square_cipher_encrypt_core #(
	parameter int ROUNDS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] plain_low,
	input  logic [63:0] plain_high,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] cipher_low,
	output logic [63:0] cipher_high,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data
);

	logic [63:0] key_lo_q, key_hi_q;
	logic [sqenc_pkg::BLK_W-1:0] key_w;
	logic [sqenc_pkg::BLK_W-1:0] rkey_q [1:ROUNDS];
	logic [sqenc_pkg::BLK_W-1:0] blk_s [0:ROUNDS];
	logic [ROUNDS:0] vld_s;
	logic [ROUNDS:0] adv;

	assign key_w = {key_hi_q, key_lo_q};
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_lo_q <= '0;
			key_hi_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sqenc_pkg::REG_KEY_LOW:  key_lo_q <= cfg_data;
				sqenc_pkg::REG_KEY_HIGH: key_hi_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// key schedule chain, one step per register
	always_ff @(posedge clk) begin
		rkey_q[1] <= sqenc_pkg::next_key(key_w, sqenc_pkg::round_const(1));
	end

	for (genvar r = 2; r <= ROUNDS; r++) begin : g_rkey
		always_ff @(posedge clk) begin
			rkey_q[r] <= sqenc_pkg::next_key(rkey_q[r-1], sqenc_pkg::round_const(r));
		end
	end

	// stage advance: a stage loads when empty or when the next one loads (the last one when out_ready is high)
	assign adv[ROUNDS] = !vld_s[ROUNDS] || out_ready;
	for (genvar i = 0; i < ROUNDS; i++) begin : g_adv
		assign adv[i] = !vld_s[i] || adv[i+1];
	end

	assign in_ready = adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (adv[0]) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			blk_s[0] <= {plain_high, plain_low} ^ sqenc_pkg::mix_rows(key_w);
		end
	end

	for (genvar r = 1; r <= ROUNDS; r++) begin : g_round
		logic [sqenc_pkg::BLK_W-1:0] pre;

		if (r == 1) begin : g_first
			assign pre = blk_s[r-1];
		end else begin : g_rest
			assign pre = sqenc_pkg::mix_rows(blk_s[r-1]);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[r] <= 1'b0;
			end else if (adv[r]) begin
				vld_s[r] <= vld_s[r-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv[r]) begin
				blk_s[r] <= sqenc_pkg::sub_transpose(pre) ^ rkey_q[r];
			end
		end
	end

	assign out_valid   = vld_s[ROUNDS];
	assign cipher_low  = blk_s[ROUNDS][63:0];
	assign cipher_high = blk_s[ROUNDS][127:64];

endmodule

FILE: design/sqenc_checker.sv
// sqenc_checker: port-level assertions for square_cipher_encrypt_core.
// Bound to the top level below; no package dependencies.
module sqenc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] cipher_low,
	input logic [63:0] cipher_high,
	input logic        cfg_valid,
	input logic        cfg_ready
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cipher_low) && $stable(cipher_high))
		else $error("result word changed while stalled");

	// when the sink takes, every stage can move, so a new block is taken too
	a_ready_follow: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output drains");

	// with the output empty the pipeline never backs up to the input
	a_empty_out: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write stalled");

endmodule

bind square_cipher_encrypt_core sqenc_checker u_sqenc_checker (.*);
